>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RSSI running-mean RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define CHK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition is never true outside reset.
`define CHK_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> rtl/core/prbm_pkg.sv
// Shared types and constants for the per-BSSID RSSI running-mean block.
`timescale 1ns / 1ps

package prbm_pkg;

  localparam int MAC_W  = 48;
  localparam int RSSI_W = 8;
  localparam int MEAN_W = 16;
  localparam int CNT_W  = 16;
  localparam int NUM_W  = 34;        // |mean*count + sample| fits here
  localparam int DVS_W  = CNT_W + 1; // count + 1 up to 65536
  localparam int DATA_W = MEAN_W + CNT_W;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam int DEF_TABLE_DEPTH = 64;

  typedef struct packed {
    logic             start;
    logic             neg;
    logic [NUM_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [MEAN_W-1:0] quotient;
  } div_rsp_t;

endpackage

>>> rtl/core/prbm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module prbm_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/prbm_div.sv
// Restoring divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps

module prbm_div
  import prbm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int SW = $clog2(NUM_W);

  logic             busy;
  logic             done;
  logic [SW-1:0]    step;
  logic             neg;
  logic [NUM_W-1:0] dvd;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W-1:0] rem;
  logic [DVS_W:0]   rem_sh;
  logic             ge;
  logic [MEAN_W-1:0] mag;

  assign rem_sh = {rem, dvd[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == SW'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      dvs <= req.divisor;
      neg <= req.neg;
      rem <= '0;
    end else if (busy) begin
      // shift in next dividend bit, quotient bits fill from the bottom
      rem <= ge ? DVS_W'(rem_sh - {1'b0, dvs}) : rem_sh[DVS_W-1:0];
      dvd <= {dvd[NUM_W-2:0], ge};
    end
  end

  assign mag          = dvd[MEAN_W-1:0];
  assign rsp.done     = done;
  assign rsp.quotient = neg ? MEAN_W'(-mag) : mag;

endmodule

>>> rtl/core/per_bssid_rssi_running_mean_unit.sv
// Top level: BSSID table search, running-mean update and result register.
`timescale 1ns / 1ps

// Tracks up to TABLE_DEPTH access points by MAC. Each beat is searched
// linearly through the MAC RAM at one entry per cycle. On a hit, a
// multiply and a bit-serial divide form the new mean; a new or dropped
// MAC goes straight on to the result register.
// One item is worked on at a time; the next beat is taken as soon as the
// previous result is in the output register. The table is emptied only by
// reset, which just zeroes the fill count, so no clearing pass is needed.

`include "assert_macros.svh"

module per_bssid_rssi_running_mean_unit
  import prbm_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [MAC_W-1:0]         mac_address,
  input  logic signed [RSSI_W-1:0] rssi_sample,
  input  logic                     last_in_scan,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [MEAN_W-1:0] mean_rssi,
  output logic [CNT_W-1:0]         detections,
  output logic                     newly_added,
  output logic                     dropped,
  output logic                     scan_done
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    IDLE, SEARCH, MUL, DIVGO, DIVWAIT, RESULT
  } state_t;

  state_t state;

  logic [CW-1:0]     used;
  logic [CW-1:0]     idx;
  logic              pend;
  logic [AW-1:0]     pend_idx;
  logic [AW-1:0]     hit_idx;

  logic [MAC_W-1:0]  item_mac;
  logic [MEAN_W-1:0] item_samp;
  logic              item_last;

  logic signed [MEAN_W-1:0] cur_mean;
  logic [CNT_W-1:0]  cur_count;
  logic signed [NUM_W-1:0] num;

  logic [MEAN_W-1:0] res_mean;
  logic [CNT_W-1:0]  res_count;
  logic              res_added;
  logic              res_drop;

  logic [MAC_W-1:0]  mac_rd;
  logic [DATA_W-1:0] data_rd;
  logic              mac_we;
  logic              data_we;
  logic [AW-1:0]     waddr;
  logic [DATA_W-1:0] data_wd;
  logic [AW-1:0]     raddr;

  logic              match;
  logic              miss;
  logic              room;
  logic signed [MEAN_W+CNT_W:0] prod;
  logic signed [NUM_W-1:0] num_next;
  logic [CNT_W-1:0]  cnt_sat;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign in_ready = (state == IDLE);
  assign match    = pend && (mac_rd == item_mac);
  assign miss     = !match && (idx >= used);
  assign room     = used < CW'(TABLE_DEPTH);
  assign raddr    = idx[AW-1:0];

  assign prod     = cur_mean * $signed({1'b0, cur_count});
  assign num_next = {prod[MEAN_W+CNT_W], prod}
                  + {{(NUM_W-MEAN_W){item_samp[MEAN_W-1]}}, item_samp};
  assign cnt_sat  = (cur_count == CNT_MAX) ? cur_count : cur_count + 1'b1;

  assign div_req.start    = (state == DIVGO);
  assign div_req.neg      = num[NUM_W-1];
  assign div_req.dividend = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign div_req.divisor  = {1'b0, cur_count} + 1'b1;

  // RAM writes: append on a miss with room, mean update on divide done
  always_comb begin
    mac_we  = 1'b0;
    data_we = 1'b0;
    waddr   = used[AW-1:0];
    data_wd = {item_samp, CNT_W'(1)};
    case (state)
      SEARCH: begin
        if (miss && room) begin
          mac_we  = 1'b1;
          data_we = 1'b1;
        end
      end
      DIVWAIT: begin
        waddr   = hit_idx;
        data_wd = {div_rsp.quotient, cnt_sat};
        data_we = div_rsp.done;
      end
      default: begin
      end
    endcase
  end

  prbm_ram #(.W(MAC_W), .DEPTH(TABLE_DEPTH)) u_mac_ram (
    .clk   (clk),
    .we    (mac_we),
    .waddr (waddr),
    .wdata (item_mac),
    .raddr (raddr),
    .rdata (mac_rd)
  );

  prbm_ram #(.W(DATA_W), .DEPTH(TABLE_DEPTH)) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (waddr),
    .wdata (data_wd),
    .raddr (raddr),
    .rdata (data_rd)
  );

  prbm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      used      <= '0;
      idx       <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // RESULT reloads the output register itself
      if (out_valid && out_ready && state != RESULT) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (in_valid) begin
            item_mac  <= mac_address;
            item_samp <= {rssi_sample, 8'h00};
            item_last <= last_in_scan;
            idx       <= '0;
            pend      <= 1'b0;
            state     <= SEARCH;
          end
        end
        SEARCH: begin
          if (match) begin
            cur_mean  <= data_rd[DATA_W-1:CNT_W];
            cur_count <= data_rd[CNT_W-1:0];
            hit_idx   <= pend_idx;
            pend      <= 1'b0;
            state     <= MUL;
          end else if (miss) begin
            pend      <= 1'b0;
            res_added <= room;
            res_drop  <= !room;
            res_mean  <= room ? item_samp : '0;
            res_count <= room ? CNT_W'(1) : '0;
            if (room) begin
              used <= used + 1'b1;
            end
            state <= RESULT;
          end else begin
            // issue the next entry; its MAC is compared in the next cycle
            pend     <= 1'b1;
            pend_idx <= idx[AW-1:0];
            idx      <= idx + 1'b1;
          end
        end
        MUL: begin
          num   <= num_next;
          state <= DIVGO;
        end
        DIVGO: begin
          state <= DIVWAIT;
        end
        DIVWAIT: begin
          if (div_rsp.done) begin
            res_mean  <= div_rsp.quotient;
            res_count <= cnt_sat;
            res_added <= 1'b0;
            res_drop  <= 1'b0;
            state     <= RESULT;
          end
        end
        RESULT: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            mean_rssi   <= res_mean;
            detections  <= res_count;
            newly_added <= res_added;
            dropped     <= res_drop;
            scan_done   <= item_last;
            state       <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  `CHK_ALWAYS(a_used_bound, used <= CW'(TABLE_DEPTH), "fill count exceeds table depth")
  `CHK_ALWAYS(a_drop_full, out_valid && dropped |-> used == CW'(TABLE_DEPTH), "drop with room left")
  `CHK_NEVER(a_add_drop, out_valid && newly_added && dropped, "beat both added and dropped")
  `CHK_ALWAYS(a_one_item, in_valid && in_ready |=> !in_ready, "second beat taken while busy")

endmodule

>>> tb/bssid_mean_checker.sv
// Checker for the per-BSSID RSSI running-mean unit: tracks the table and compares each result.
`timescale 1ns / 1ps

module bssid_mean_checker
  import prbm_pkg::*;
#(
  parameter int DEPTH = DEF_TABLE_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [MAC_W-1:0]         mac_address,
  input  logic signed [RSSI_W-1:0] rssi_sample,
  input  logic                     last_in_scan,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic signed [MEAN_W-1:0] mean_rssi,
  input  logic [CNT_W-1:0]         detections,
  input  logic                     newly_added,
  input  logic                     dropped,
  input  logic                     scan_done,
  output int                       mismatches,
  output int                       pending,
  output int                       n_checked,
  output int                       n_added,
  output int                       n_dropped
);

  typedef struct packed {
    logic [MEAN_W-1:0] mean;
    logic [CNT_W-1:0]  count;
    logic              added;
    logic              spill;
    logic              scan_end;
  } ap_update_t;

  logic [MAC_W-1:0]         ap_mac   [DEPTH];
  logic signed [MEAN_W-1:0] ap_mean  [DEPTH];
  logic [CNT_W-1:0]         ap_count [DEPTH];
  int                       ap_used = 0;

  ap_update_t due_results[$];

  initial begin
    mismatches = 0;
    pending    = 0;
    n_checked  = 0;
    n_added    = 0;
    n_dropped  = 0;
  end

  // Update the tracked table for one observation and return the result it yields.
  function automatic ap_update_t track_observation(input logic [MAC_W-1:0] m,
                                                   input logic signed [RSSI_W-1:0] s,
                                                   input logic last);
    ap_update_t r;
    longint     c;
    longint     num;
    longint     q;
    int         slot;
    int         i;
    r = '0;
    r.scan_end = last;
    slot = -1;
    for (i = 0; i < ap_used; i++) begin
      if (slot < 0 && ap_mac[i] == m) slot = i;
    end
    if (slot >= 0) begin
      c = ap_count[slot];
      num = longint'(ap_mean[slot]) * c + longint'(s) * 256;
      // signed divide truncates toward zero
      q = num / (c + 1);
      ap_mean[slot] = q[MEAN_W-1:0];
      if (ap_count[slot] != CNT_MAX) ap_count[slot] = ap_count[slot] + 1'b1;
      r.mean  = ap_mean[slot];
      r.count = ap_count[slot];
    end else if (ap_used < DEPTH) begin
      ap_mac[ap_used]   = m;
      ap_mean[ap_used]  = MEAN_W'(longint'(s) * 256);
      ap_count[ap_used] = 1;
      r.mean  = ap_mean[ap_used];
      r.count = 1;
      r.added = 1'b1;
      ap_used++;
      n_added++;
    end else begin
      r.spill = 1'b1;
      n_dropped++;
    end
    return r;
  endfunction

  task automatic log_mismatch(input string msg);
    $display("%0t ns: MISMATCH %s", $time, msg);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input longint got, input longint want);
    if (got != want)
      log_mismatch($sformatf("%s: got %0d, expected %0d (beat %0d)", name, got, want, n_checked));
  endtask

  always @(posedge clk) begin : watch
    ap_update_t want;
    if (!rst) begin
      // push first so a same-edge result still finds its expectation
      if (in_valid && in_ready)
        due_results.push_back(track_observation(mac_address, rssi_sample, last_in_scan));
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          log_mismatch("result beat with nothing expected");
        end else begin
          want = due_results.pop_front();
          compare_field("mean_rssi", mean_rssi, $signed(want.mean));
          compare_field("detections", detections, want.count);
          compare_field("newly_added", newly_added, want.added);
          compare_field("dropped", dropped, want.spill);
          compare_field("scan_done", scan_done, want.scan_end);
          n_checked++;
        end
      end
    end
    pending <= due_results.size();
  end

endmodule

>>> tb/per_bssid_rssi_running_mean_unit_test.sv
// Top of the running-mean testbench: clock, reset, beat stimulus and verdict.
`timescale 1ns / 1ps

module per_bssid_rssi_running_mean_unit_test;
  import prbm_pkg::*;

  localparam int DEPTH = DEF_TABLE_DEPTH;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [MAC_W-1:0]         mac_address = '0;
  logic signed [RSSI_W-1:0] rssi_sample = '0;
  logic                     last_in_scan = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [MEAN_W-1:0] mean_rssi;
  logic [CNT_W-1:0]         detections;
  logic                     newly_added;
  logic                     dropped;
  logic                     scan_done;

  int mismatches;
  int pending;
  int n_checked;
  int n_added;
  int n_dropped;

  int send_idle_pct = 21;
  int recv_idle_pct = 83;
  int beats_sent = 0;

  // MACs that hold a table slot, and a few that were turned away when it was full
  logic [MAC_W-1:0] tracked[$];
  logic [MAC_W-1:0] spilled[$];

  always #2 clk = ~clk;

  per_bssid_rssi_running_mean_unit #(.TABLE_DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .mac_address(mac_address), .rssi_sample(rssi_sample), .last_in_scan(last_in_scan),
    .out_valid(out_valid), .out_ready(out_ready),
    .mean_rssi(mean_rssi), .detections(detections), .newly_added(newly_added),
    .dropped(dropped), .scan_done(scan_done)
  );

  bssid_mean_checker #(.DEPTH(DEPTH)) u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .mac_address(mac_address), .rssi_sample(rssi_sample), .last_in_scan(last_in_scan),
    .out_valid(out_valid), .out_ready(out_ready),
    .mean_rssi(mean_rssi), .detections(detections), .newly_added(newly_added),
    .dropped(dropped), .scan_done(scan_done),
    .mismatches(mismatches), .pending(pending), .n_checked(n_checked),
    .n_added(n_added), .n_dropped(n_dropped)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  function automatic void note_mac(input logic [MAC_W-1:0] m);
    bit seen = 0;
    foreach (tracked[i]) if (tracked[i] == m) seen = 1;
    if (!seen && tracked.size() < DEPTH) tracked.push_back(m);
    else if (!seen && spilled.size() < 16) spilled.push_back(m);
  endfunction

  // Hold valid and payload until the beat is taken; drop valid only in a gap.
  task automatic send_beat(input logic [MAC_W-1:0] m, input logic signed [RSSI_W-1:0] s,
                           input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    mac_address  <= m;
    rssi_sample  <= s;
    last_in_scan <= last;
    do @(posedge clk); while (!in_ready);
    note_mac(m);
    beats_sent++;
  endtask

  task automatic random_phase(input int n, input int s_idle, input int r_idle);
    logic [MAC_W-1:0]         m;
    logic signed [RSSI_W-1:0] s;
    bit [31:0]                hi;
    bit [31:0]                lo;
    int                       pick;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      hi = $urandom;
      lo = $urandom;
      if (pick < 12 || tracked.size() == 0)
        m = {hi[15:0], lo};
      else if (pick < 20)
        // one bit off a tracked MAC
        m = tracked[$urandom_range(0, tracked.size() - 1)]
            ^ (48'd1 << $urandom_range(0, MAC_W - 1));
      else if (pick < 24 && spilled.size() != 0)
        m = spilled[$urandom_range(0, spilled.size() - 1)];
      else
        m = tracked[$urandom_range(0, tracked.size() - 1)];
      pick = $urandom_range(0, 19);
      if (pick == 0)      s = 8'h80;
      else if (pick == 1) s = 8'h7F;
      else                s = RSSI_W'($urandom_range(0, 255));
      send_beat(m, s, $urandom_range(0, 7) == 0);
    end
  endtask

  initial begin
    #10_000_000;
    $display("timeout with %0d results still expected", pending);
    $display("per_bssid_rssi_running_mean_unit_test NOT OK");
    $finish;
  end

  initial begin : stimulus
    int waited;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // extremes of MAC and sample, then means pulled together
    send_beat(48'h0000_0000_0000, 8'h80, 1'b0);
    send_beat(48'hFFFF_FFFF_FFFF, 8'h7F, 1'b1);
    send_beat(48'h0000_0000_0000, 8'h7F, 1'b0);
    send_beat(48'hFFFF_FFFF_FFFF, 8'h80, 1'b0);
    // truncation toward zero on negative and positive means
    send_beat(48'h0000_0000_0001, 8'hFF, 1'b0);
    send_beat(48'h0000_0000_0001, 8'h00, 1'b0);
    send_beat(48'h0000_0000_0001, 8'h00, 1'b1);
    send_beat(48'h8000_0000_0000, 8'h01, 1'b0);
    send_beat(48'h8000_0000_0000, 8'h00, 1'b0);
    send_beat(48'h8000_0000_0000, 8'h00, 1'b0);
    // near misses of a tracked MAC must not hit it
    send_beat(48'hA5A5_5A5A_F00F, 8'h00, 1'b0);
    send_beat(48'hA5A5_5A5A_F00E, 8'hC4, 1'b0);
    send_beat(48'h25A5_5A5A_F00F, 8'h3B, 1'b1);
    send_beat(48'hA5A5_5A5A_F00F, 8'hA7, 1'b0);
    send_beat(48'h5A5A_A5A5_0FF0, 8'h55, 1'b0);
    send_beat(48'h0000_0000_0000, 8'h80, 1'b0);
    send_beat(48'hFFFF_FFFF_FFFF, 8'h7F, 1'b1);
    send_beat(48'h0000_0000_0001, 8'hFF, 1'b0);

    // the table fills early in the first phase; later fresh MACs get dropped
    random_phase(630, 21, 83);
    random_phase(630, 83, 21);
    random_phase(630, 0, 0);
    in_valid <= 1'b0;

    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (pending != 0 && waited < 20000);
    repeat (150) @(posedge clk);

    if (pending != 0) $display("%0d expected results never arrived", pending);
    $display("sent %0d beats, checked %0d results: %0d new entries, %0d updates, %0d dropped",
             beats_sent, n_checked, n_added, n_checked - n_added - n_dropped, n_dropped);
    $display("table filled to %0d of %0d slots, %0d mismatches",
             tracked.size(), DEPTH, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("per_bssid_rssi_running_mean_unit_test OK");
    end else begin
      $display("per_bssid_rssi_running_mean_unit_test NOT OK");
    end
    $finish;
  end

endmodule
